### design/indexed_list_store_assert.svh
// Assertion macros for the indexed list store.
`ifndef INDEXED_LIST_STORE_ASSERT_SVH
`define INDEXED_LIST_STORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on i_clk, off during reset.
`define ILS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, sampled on i_clk, off during reset.
`define ILS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ILS_ASSERT_IMP(lbl, ante, cons)
`define ILS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### design/ils_pkg.sv
// Shared widths, operation and status codes, and controller/datapath links.
package ils_pkg;

    localparam int KIND_W = 3;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 7;

    localparam logic [KIND_W-1:0] KIND_READ   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HEAD   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TAIL   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BEFORE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic load_op;    // latch the accepted item
        logic rd_en;      // issue a RAM read
        logic rd_cursor;  // read at the shift cursor, else at the item position
        logic wr_en;      // write the RAM
        logic wr_put;     // write the new value at the insert slot, else moved data
        logic start;      // set up the shift cursor
        logic step;       // advance the shift cursor
        logic finish;     // load the result and update the length
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic read_hit;
        logic insert;         // insert that will be carried out
        logic insert_direct;  // nothing to move before the insert
        logic delete;         // delete that will be carried out
        logic delete_direct;  // last entry removed, nothing to move
        logic last;           // cursor at the final read of the shift
        logic out_free;       // result register can take a new item
    } t_dp_stat;

endpackage

### design/ils_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/ils_ctrl.sv
// Operation sequencer: decode, read wait, entry shift, insert write, result hand-off.
module ils_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ils_pkg::t_dp_stat i_stat,
    output ils_pkg::t_dp_cmd  o_cmd
);

    import ils_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD_WAIT,
        S_SHIFT,
        S_DRAIN,
        S_PUT,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_pend, n_pend;

    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_op = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_pend = 1'b0;
                priority if (i_stat.read_hit) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_RD_WAIT;
                end else if (i_stat.insert) begin
                    if (i_stat.insert_direct) begin
                        n_state = S_PUT;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = S_SHIFT;
                    end
                end else if (i_stat.delete) begin
                    if (i_stat.delete_direct) begin
                        n_state = S_FINISH;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = S_SHIFT;
                    end
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_RD_WAIT: begin
                n_state = S_FINISH;
            end
            S_SHIFT: begin
                // read the next entry while the previous one lands one place over
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_cursor = 1'b1;
                o_cmd.wr_en     = r_pend;
                o_cmd.step      = 1'b1;
                n_pend          = 1'b1;
                if (i_stat.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.wr_en = 1'b1;
                n_state     = i_stat.insert ? S_PUT : S_FINISH;
            end
            S_PUT: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_put = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

### design/ils_dp.sv
// Datapath: latched item, length counter, shift cursors, entry RAM and result register.
module ils_dp #(
    parameter int CAPACITY = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ils_pkg::t_dp_cmd                  i_cmd,
    output ils_pkg::t_dp_stat                 o_stat,
    input  logic [ils_pkg::KIND_W-1:0]        i_kind,
    input  logic [ils_pkg::POS_W-1:0]         i_position,
    input  logic signed [ils_pkg::VAL_W-1:0]  i_item_value,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic                              o_found,
    output logic signed [ils_pkg::VAL_W-1:0]  o_read_value,
    output logic [ils_pkg::STAT_W-1:0]        o_status,
    output logic [ils_pkg::LEN_W-1:0]         o_list_length
);

    import ils_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic [KIND_W-1:0] r_kind;
    logic [POS_W-1:0]  r_pos;
    logic [VAL_W-1:0]  r_val;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_ra;
    logic [AW-1:0]     r_wa;

    logic                     r_out_valid;
    logic                     r_out_found;
    logic signed [VAL_W-1:0]  r_out_rdval;
    logic [STAT_W-1:0]        r_out_status;
    logic [LEN_W-1:0]         r_out_len;

    logic [CMPW-1:0]   pos_ext, cnt_ext;
    logic              full;
    logic              pos_lt_cnt;
    logic [STAT_W-1:0] op_status;
    logic              is_ins_kind;
    logic [AW-1:0]     ins_pos;
    logic [AW-1:0]     last_del;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [VAL_W-1:0]  wr_data, rd_data;

    assign pos_ext    = CMPW'(r_pos);
    assign cnt_ext    = CMPW'(r_count);
    assign full       = (r_count == CW'(CAPACITY));
    assign pos_lt_cnt = (pos_ext < cnt_ext);

    always_comb begin
        op_status   = ST_DONE;
        is_ins_kind = 1'b0;
        ins_pos     = '0;
        unique case (r_kind)
            KIND_READ: begin
                op_status = ST_DONE;
            end
            KIND_HEAD: begin
                is_ins_kind = 1'b1;
                op_status   = full ? ST_FULL : ST_DONE;
            end
            KIND_TAIL: begin
                is_ins_kind = 1'b1;
                ins_pos     = AW'(r_count);
                op_status   = full ? ST_FULL : ST_DONE;
            end
            KIND_BEFORE: begin
                is_ins_kind = 1'b1;
                ins_pos     = AW'(r_pos);
                // range check wins over the full check
                priority if (pos_ext > cnt_ext) begin
                    op_status = ST_RANGE;
                end else if (full) begin
                    op_status = ST_FULL;
                end else begin
                    op_status = ST_DONE;
                end
            end
            KIND_DELETE: begin
                op_status = pos_lt_cnt ? ST_DONE : ST_RANGE;
            end
            default: begin
                op_status = ST_DONE;
            end
        endcase
    end

    assign last_del = AW'(r_count - CW'(1));

    always_comb begin
        o_stat               = '0;
        o_stat.read_hit      = (r_kind == KIND_READ) && pos_lt_cnt;
        o_stat.insert        = is_ins_kind && (op_status == ST_DONE);
        o_stat.insert_direct = (CW'(ins_pos) == r_count);
        o_stat.delete        = (r_kind == KIND_DELETE) && pos_lt_cnt;
        o_stat.delete_direct = (cnt_ext == CMPW'(pos_ext + CMPW'(1)));
        o_stat.last          = o_stat.insert ? (r_ra == ins_pos) : (r_ra == last_del);
        o_stat.out_free      = !r_out_valid || !i_out_stall;
    end

    assign rd_addr = i_cmd.rd_cursor ? r_ra : AW'(r_pos);
    assign wr_addr = i_cmd.wr_put ? ins_pos : r_wa;
    assign wr_data = i_cmd.wr_put ? r_val : rd_data;

    ils_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_count = r_count;
        if (o_stat.insert) begin
            n_count = r_count + CW'(1);
        end else if (o_stat.delete) begin
            n_count = r_count - CW'(1);
        end
    end

    // Item, cursor and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_op) begin
            r_kind <= i_kind;
            r_pos  <= i_position;
            r_val  <= i_item_value;
        end
        if (i_cmd.start) begin
            r_ra <= o_stat.insert ? last_del : AW'(pos_ext + CMPW'(1));
        end else if (i_cmd.step) begin
            if (o_stat.insert) begin
                r_wa <= r_ra + AW'(1);
                r_ra <= r_ra - AW'(1);
            end else begin
                r_wa <= r_ra - AW'(1);
                r_ra <= r_ra + AW'(1);
            end
        end
        if (i_cmd.finish) begin
            r_out_found  <= o_stat.read_hit;
            r_out_rdval  <= o_stat.read_hit ? $signed(rd_data) : '1;
            r_out_status <= op_status;
            r_out_len    <= LEN_W'(n_count);
        end
    end

    // Length and result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_out_found;
    assign o_read_value  = r_out_rdval;
    assign o_status      = r_out_status;
    assign o_list_length = r_out_len;

endmodule

### design/indexed_list_store.sv
// Indexed list store: ordered list of signed 32-bit values in a RAM.
//
// Input channel (i_in_valid / o_in_stall): one item per operation, given by
// i_kind (read, insert head, insert tail, insert before index, delete),
// i_position and i_item_value. Output channel (o_out_valid / i_out_stall):
// exactly one result item per operation with o_found, o_read_value, o_status
// and o_list_length (length after the operation, modulo 128).
// One operation is in flight at a time. After decode, a read hit waits for
// the RAM read; a read miss, a rejected or unknown op and a delete of the
// last entry go straight to the result; another delete moves the entries
// after the deleted one down one place; an insert writes the new value, first
// moving the entries from its slot up one place if any. The entry RAM has one
// write and one read port, so entries are moved in a read-ahead/write-behind loop.
// A new item is accepted once the previous result is registered, even while
// that result is still stalled; a finished operation waits in its last step
// until the result register is free. Reset empties the list at once; the
// RAM contents are not cleared and are never read before being written.
`include "indexed_list_store_assert.svh"

module indexed_list_store #(
    parameter int CAPACITY = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ils_pkg::KIND_W-1:0]        i_kind,
    input  logic [ils_pkg::POS_W-1:0]         i_position,
    input  logic signed [ils_pkg::VAL_W-1:0]  i_item_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_found,
    output logic signed [ils_pkg::VAL_W-1:0]  o_read_value,
    output logic [ils_pkg::STAT_W-1:0]        o_status,
    output logic [ils_pkg::LEN_W-1:0]         o_list_length
);

    import ils_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ils_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ils_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_kind        (i_kind),
        .i_position    (i_position),
        .i_item_value  (i_item_value),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_found       (o_found),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_list_length (o_list_length)
    );

    // An accepted item keeps the input side busy in the next cycle
    `ILS_ASSERT_NXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    // A read hit always completes normally
    `ILS_ASSERT_IMP(a_hit_is_done, o_out_valid && o_found, o_status == ST_DONE)
    // A rejected operation reports no data
    `ILS_ASSERT_IMP(a_reject_no_data, o_out_valid && o_status != ST_DONE, !o_found && o_read_value == '1)
    // Results appear only after the controller has left its idle state
    `ILS_ASSERT_IMP(a_finish_when_busy, cmd.finish, o_in_stall)

endmodule
